// ===== hdl/modexp_pkg.sv =====
package modexp_pkg;

    localparam int OPERAND_BITS  = 32;
    localparam int EXPONENT_BITS = 63;

    // fixed field widths of the ports
    localparam int BASE_W   = 32;
    localparam int EXP_W    = 63;
    localparam int MOD_W    = 32;
    localparam int RESULT_W = 32;

    // bit counter of the serial multiplier, holds OPERAND_BITS itself
    localparam int CNT_W = $clog2(OPERAND_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_REDUCE,
        S_LOOP,
        S_STEP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                    start;
        logic [OPERAND_BITS-1:0] x;
        logic [OPERAND_BITS-1:0] y;
        logic [OPERAND_BITS-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// Sequence: a zero modulus goes straight to the finish state; otherwise one reduction
//   pass of the base, then one square pass per exponent bit up to the top set bit,
//   with the multiply pass running alongside it where that bit is set.
// Each exponent bit costs one pass of the bit-serial multipliers (one bit per cycle).
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module modular_exponentiation
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [modexp_pkg::BASE_W-1:0]      base_value,
    input  logic [modexp_pkg::EXP_W-1:0]       exponent_value,
    input  logic [modexp_pkg::MOD_W-1:0]       modulus_value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [modexp_pkg::RESULT_W-1:0]    power_result
);

    localparam int N = modexp_pkg::OPERAND_BITS;
    localparam int E = modexp_pkg::EXPONENT_BITS;

    modexp_pkg::state_t state_reg;
    modexp_pkg::state_t state_next;

    logic [N-1:0] base_reg;
    logic [E-1:0] exp_reg;
    logic [N-1:0] mod_reg;
    logic [N-1:0] acc_reg;
    logic         rsp_valid_reg;
    logic [modexp_pkg::RESULT_W-1:0] power_result_reg;

    logic accept;
    logic out_free;
    logic exp_zero;

    modexp_pkg::mm_req_t  mul_req;
    modexp_pkg::mm_req_t  sq_req;
    modexp_pkg::mm_stat_t mul_stat;
    modexp_pkg::mm_stat_t sq_stat;
    logic [N-1:0]         mul_result;
    logic [N-1:0]         sq_result;

    assign req_stall = (state_reg != modexp_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign exp_zero  = (exp_reg == '0);

    always_comb
    begin
        mul_req.start = (state_reg == modexp_pkg::S_LOOP) && !exp_zero && exp_reg[0];
        mul_req.x     = acc_reg;
        mul_req.y     = base_reg;
        mul_req.m     = mod_reg;

        // the load pass reduces the raw base as base * 1 mod m
        sq_req.start  = (state_reg == modexp_pkg::S_LOAD) ||
                        ((state_reg == modexp_pkg::S_LOOP) && !exp_zero);
        sq_req.x      = base_reg;
        sq_req.y      = (state_reg == modexp_pkg::S_LOAD) ? N'(1) : base_reg;
        sq_req.m      = mod_reg;
    end

    modexp_mulmod u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .stat   (mul_stat),
        .result (mul_result)
    );

    modexp_mulmod u_sq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sq_req),
        .stat   (sq_stat),
        .result (sq_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (modulus_value[N-1:0] == '0)
                    begin
                        state_next = modexp_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = modexp_pkg::S_LOAD;
                    end
                end
            end
            modexp_pkg::S_LOAD:
            begin
                state_next = modexp_pkg::S_REDUCE;
            end
            modexp_pkg::S_REDUCE:
            begin
                if (sq_stat.done)
                begin
                    state_next = modexp_pkg::S_LOOP;
                end
            end
            modexp_pkg::S_LOOP:
            begin
                if (exp_zero)
                begin
                    state_next = modexp_pkg::S_FINISH;
                end
                else
                begin
                    state_next = modexp_pkg::S_STEP;
                end
            end
            modexp_pkg::S_STEP:
            begin
                if (sq_stat.done)
                begin
                    state_next = modexp_pkg::S_LOOP;
                end
            end
            modexp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = modexp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = modexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == modexp_pkg::S_FINISH) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            modexp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    base_reg <= base_value[N-1:0];
                    exp_reg  <= exponent_value[E-1:0];
                    mod_reg  <= modulus_value[N-1:0];
                    // zero modulus gives zero; otherwise start from one, unreduced
                    acc_reg  <= (modulus_value[N-1:0] == '0) ? '0 : N'(1);
                end
            end
            modexp_pkg::S_REDUCE:
            begin
                if (sq_stat.done)
                begin
                    base_reg <= sq_result;
                end
            end
            modexp_pkg::S_STEP:
            begin
                if (sq_stat.done)
                begin
                    if (exp_reg[0])
                    begin
                        acc_reg <= mul_result;
                    end
                    base_reg <= sq_result;
                    exp_reg  <= {1'b0, exp_reg[E-1:1]};
                end
            end
            modexp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    power_result_reg <= modexp_pkg::RESULT_W'(acc_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid    = rsp_valid_reg;
    assign power_result = power_result_reg;

`ifndef SYNTHESIS
    a_mul_busy_with_sq: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.busy |-> sq_stat.busy)
        else $error("multiply pass running without square pass");

    a_mul_done_with_sq: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> sq_stat.done)
        else $error("multiply pass finished out of step with square pass");

    a_step_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == modexp_pkg::S_STEP) |-> (sq_stat.busy || sq_stat.done))
        else $error("step state without a running square pass");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(power_result)))
        else $error("stalled result changed");
`endif

endmodule

// ===== hdl/modexp_mulmod.sv =====
// Serial modular multiplier: x scanned MSB first, one bit per cycle,
// r = 2r + bit*y reduced by one subtraction of 2m or of m where needed.
module modexp_mulmod
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  modexp_pkg::mm_req_t                  req,
    output modexp_pkg::mm_stat_t                 stat,
    output logic [modexp_pkg::OPERAND_BITS-1:0]  result
);

    localparam int N = modexp_pkg::OPERAND_BITS;

    logic [N-1:0]                  x_reg;
    logic [N-1:0]                  y_reg;
    logic [N-1:0]                  m_reg;
    logic [N-1:0]                  r_reg;
    logic [N-1:0]                  r_next;
    logic [modexp_pkg::CNT_W-1:0]  cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [N+1:0] t_sum;
    logic [N+1:0] m1_ext;
    logic [N+1:0] m2_ext;

    always_comb
    begin
        m1_ext = {2'b00, m_reg};
        m2_ext = {1'b0, m_reg, 1'b0};
        t_sum  = {1'b0, r_reg, 1'b0} + {2'b00, (x_reg[N-1] ? y_reg : '0)};
        // t_sum < 3m since r < m and y <= m
        if (t_sum >= m2_ext)
        begin
            r_next = N'(t_sum - m2_ext);
        end
        else if (t_sum >= m1_ext)
        begin
            r_next = N'(t_sum - m1_ext);
        end
        else
        begin
            r_next = N'(t_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= modexp_pkg::CNT_W'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == modexp_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            m_reg <= req.m;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[N-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (r_reg < m_reg))
        else $error("partial remainder not below modulus");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished run");
`endif

endmodule

// ===== bench/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;

    typedef struct {
        logic [modexp_pkg::BASE_W-1:0]   base;
        logic [modexp_pkg::EXP_W-1:0]    exponent;
        logic [modexp_pkg::MOD_W-1:0]    modulus;
        logic [modexp_pkg::RESULT_W-1:0] power;
    } power_request_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG
    } stall_mode_t;

    localparam int PEND_DEPTH = 512;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic [modexp_pkg::BASE_W-1:0]       base_value = '0;
    logic [modexp_pkg::EXP_W-1:0]        exponent_value = '0;
    logic [modexp_pkg::MOD_W-1:0]        modulus_value = '0;
    logic                                rsp_valid;
    logic                                rsp_stall = 1'b0;
    logic [modexp_pkg::RESULT_W-1:0]     power_result;

    // ring of requests still waiting for their result
    power_request_t expected_powers [PEND_DEPTH];
    int             pend_wr = 0;
    int             pend_rd = 0;
    power_request_t oldest_power;
    int             errors = 0;
    bit             gaps_on = 1'b0;
    int             burst_left = 1;

    stall_mode_t    stall_mode = STALL_NONE;
    int             mode_left = 0;
    int             stall_run = 0;
    bit             stall_hold = 1'b0;

    modular_exponentiation dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .power_result   (power_result)
    );

    always #5 clk = ~clk;

    // right-to-left square and multiply with exact 64-bit products
    function automatic logic [modexp_pkg::RESULT_W-1:0] predict_power(
        input logic [modexp_pkg::BASE_W-1:0] b,
        input logic [modexp_pkg::EXP_W-1:0]  e,
        input logic [modexp_pkg::MOD_W-1:0]  m
    );
        logic [63:0] op_mask;
        logic [63:0] mod64;
        logic [63:0] acc;
        logic [63:0] sq;
        op_mask = (64'd1 << modexp_pkg::OPERAND_BITS) - 64'd1;
        mod64 = 64'(m) & op_mask;
        if (mod64 == 64'd0)
        begin
            return '0;
        end
        sq = (64'(b) & op_mask) % mod64;
        acc = 64'd1;
        for (int i = 0; i < modexp_pkg::EXPONENT_BITS; i++)
        begin
            if (e[i])
            begin
                acc = (acc * sq) % mod64;
            end
            sq = (sq * sq) % mod64;
        end
        return acc[modexp_pkg::RESULT_W-1:0];
    endfunction

    function automatic int pending_count();
        return pend_wr - pend_rd;
    endfunction

    task automatic send_request(
        input logic [modexp_pkg::BASE_W-1:0] b,
        input logic [modexp_pkg::EXP_W-1:0]  e,
        input logic [modexp_pkg::MOD_W-1:0]  m
    );
        power_request_t entry;
        req_valid <= 1'b1;
        base_value <= b;
        exponent_value <= e;
        modulus_value <= m;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        entry.base = b;
        entry.exponent = e;
        entry.modulus = m;
        entry.power = predict_power(b, e, m);
        expected_powers[pend_wr % PEND_DEPTH] = entry;
        pend_wr++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_count() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_edge_operands();
        gaps_on = 1'b0;
        send_request(32'd0, 63'd0, 32'd1);
        send_request(32'd5, 63'd0, 32'd1);
        send_request(32'hFFFF_FFFF, 63'd0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, {modexp_pkg::EXP_W{1'b1}}, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, {modexp_pkg::EXP_W{1'b1}}, 32'hFFFF_FFFF);
        send_request(32'd0, 63'd5, 32'd7);
        send_request(32'd1, {modexp_pkg::EXP_W{1'b1}}, 32'hFFFF_FFFF);
        send_request(32'd2, 63'd1 << (modexp_pkg::EXP_W - 1), 32'hFFFF_FFFF);
        send_request(32'd3, 63'd1, 32'd2);
        send_request(32'hFFFF_FFFF, 63'd1, 32'd1);
        send_request(32'd2, 63'd31, 32'h8000_0000);
        // base equal to modulus reduces to zero
        send_request(32'd1000, 63'd3, 32'd1000);
        send_request(32'd999, 63'd2, 32'd1000);
        // Fermat: a^(p-1) = 1 mod largest 32-bit prime
        send_request(32'hFFFF_FFFE, 63'd4294967290, 32'd4294967291);
        send_request(32'd7, 63'd4294967290, 32'd4294967291);
        // zero modulus gives zero
        send_request(32'd9, 63'd9, 32'd0);
        send_request(32'd9, 63'd0, 32'd0);
        send_request(32'd123456789, 63'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_request(32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 63'd2, 32'hFFFF_FFFF);
        send_request(32'd2, 63'd64, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int count, input bit with_gaps);
        logic [modexp_pkg::MOD_W-1:0]  m;
        logic [modexp_pkg::BASE_W-1:0] b;
        logic [63:0]                   raw;
        logic [modexp_pkg::EXP_W-1:0]  e;
        int                            w;
        gaps_on = with_gaps;
        burst_left = $urandom_range(1, 8);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    m = $urandom_range(1, 16);
                2:       m = 32'hFFFF_FFFF - $urandom_range(0, 8);
                3:       m = {1'b1, 31'($urandom)};
                default: m = $urandom;
            endcase
            if (m == '0)
            begin
                m = 32'd1;
            end
            case ($urandom_range(0, 7))
                0:       b = '0;
                1:       b = m - 32'd1;
                2:       b = m + $urandom_range(0, 3);
                3:       b = $urandom_range(0, 3);
                default: b = $urandom;
            endcase
            w = $urandom_range(0, modexp_pkg::EXP_W);
            raw = {$urandom, $urandom};
            if (w == 0)
            begin
                e = '0;
            end
            else
            begin
                e = modexp_pkg::EXP_W'(raw & ((64'd1 << w) - 64'd1));
                e[w-1] = 1'b1;
            end
            send_request(b, e, m);
        end
    endtask

    task automatic test_drain_pause();
        gaps_on = 1'b0;
        send_request($urandom, {modexp_pkg::EXP_W{1'b1}}, $urandom | 32'd1);
        send_request($urandom, 63'($urandom), $urandom | 32'd1);
        req_valid <= 1'b0;
        wait_for_drain();
        send_request($urandom, 63'($urandom), $urandom | 32'd1);
        send_request(32'd3, 63'd0, 32'd1);
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_count() == 0)
            begin
                $display("%0t: unexpected power_result, expected none, actual %h",
                         $time, power_result);
                errors++;
            end
            else
            begin
                oldest_power = expected_powers[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (power_result !== oldest_power.power)
                begin
                    $display({"%0t: power_result mismatch (base %h exp %h mod %h): ",
                              "expected %h, actual %h"},
                             $time, oldest_power.base, oldest_power.exponent,
                             oldest_power.modulus, oldest_power.power, power_result);
                    errors++;
                end
            end
        end
        if (mode_left <= 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(64, 512);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run <= 0)
                begin
                    stall_run = $urandom_range(1, 25);
                    stall_hold = !stall_hold;
                end
                stall_run--;
                rsp_stall <= stall_hold;
            end
        endcase
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_operands();
        test_random_traffic(140, 1'b1);
        test_drain_pause();
        test_random_traffic(130, 1'b0);
        req_valid <= 1'b0;
        wait_for_drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("modular_exponentiation verification clean");
        end
        else
        begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

    initial
    begin
        #30000000;
        $display("modular_exponentiation verification failed");
        $finish;
    end

endmodule
